[rtl/ulc_pkg.sv]
`default_nettype none

package ulc_pkg;

    // default sizes
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_KEY_BITS = 32;

    // fixed field widths
    localparam int REQ_BITS   = 3;
    localparam int KEY_FIELD  = 32;
    localparam int CNT_FIELD  = 5;

    // request codes
    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT  = 3'd0,
        REQ_DELETE  = 3'd1,
        REQ_GET     = 3'd2,
        REQ_ADVANCE = 3'd3,
        REQ_CLEAR   = 3'd4
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // request transaction
    typedef struct packed {
        logic [REQ_BITS-1:0]  req_type;
        logic [KEY_FIELD-1:0] key_in;
    } t_in;

    // result transaction
    typedef struct packed {
        t_status              status;
        logic [KEY_FIELD-1:0] key_out;
        logic [CNT_FIELD-1:0] entry_count;
    } t_out;

    // per-cycle strobes shared by every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/ulc_cell.sv]
`default_nettype none

module ulc_cell #(
    parameter int CAPACITY = ulc_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = ulc_pkg::DEF_KEY_BITS,
    parameter int INDEX    = 0
) (
    input  wire                           i_clk,
    input  wire ulc_pkg::t_cell_ctl       i_ctl,
    input  wire [KEY_BITS-1:0]            i_key,
    input  wire [$clog2(CAPACITY+1)-1:0]  i_count,
    input  wire [$clog2(CAPACITY)-1:0]    i_rd_idx,
    input  wire [KEY_BITS-1:0]            i_next_entry,
    input  wire                           i_found,
    input  wire [KEY_BITS-1:0]            i_rd,
    output logic [KEY_BITS-1:0]           o_entry,
    output logic                          o_found,
    output logic [KEY_BITS-1:0]           o_rd
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int PW = $clog2(CAPACITY);

    logic [KEY_BITS-1:0] r_entry;
    logic [KEY_BITS-1:0] n_entry;
    logic                valid;
    logic                match;

    // match against the key, first hit wins along the chain
    always_comb begin
        valid   = i_count > CW'(INDEX);
        match   = valid && (r_entry == i_key);
        o_found = i_found || match;
    end

    // read-out chain for the cursor slot
    always_comb begin
        if (i_rd_idx == PW'(INDEX)) begin
            o_rd = i_rd | r_entry;
        end else begin
            o_rd = i_rd;
        end
    end

    // append, shift down on delete, else hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && (i_count == CW'(INDEX))) begin
            n_entry = i_key;
        end else if (i_ctl.del && o_found) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[rtl/unsorted_list_with_cursor.sv]
// result: a request accepted at one edge has its result registered at that same edge
// throughput: one request per cycle while o_in_ready is high; a new request is taken
//   while the result register drains; the cell row compares and shifts combinationally
// reset: synchronous active low; count and cursor go to zero, no result pending,
//   the key cells are not cleared and are read only below the count
`default_nettype none

module unsorted_list_with_cursor #(
    parameter int CAPACITY = ulc_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = ulc_pkg::DEF_KEY_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire ulc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output ulc_pkg::t_out      o_out
);

    localparam int CW = $clog2(CAPACITY+1);
    localparam int PW = $clog2(CAPACITY);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [PW-1:0]        r_cursor;
    logic [PW-1:0]        n_cursor;
    logic                 r_out_valid;
    ulc_pkg::t_out        r_out;
    ulc_pkg::t_out        n_out;

    logic                 acc;
    logic                 full;
    logic                 empty;
    logic [KEY_BITS-1:0]  key;
    logic [PW-1:0]        rd_idx;
    logic [PW-1:0]        adv_cursor;
    logic [CW-1:0]        cur_inc;
    logic [CW-1:0]        del_count;
    logic [PW-1:0]        del_cursor;
    logic                 hit;
    ulc_pkg::t_cell_ctl   ctl;

    logic [KEY_BITS-1:0]  entry_w [CAPACITY];
    logic [CAPACITY:0]    found_w;
    logic [KEY_BITS-1:0]  rd_w    [CAPACITY+1];

    // handshake
    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // request decode helpers
    always_comb begin
        key        = KEY_BITS'(i_in.key_in);
        full       = r_count == CW'(CAPACITY);
        empty      = r_count == '0;
        cur_inc    = CW'(r_cursor) + CW'(1);
        adv_cursor = (cur_inc >= r_count) ? '0 : PW'(cur_inc);
        rd_idx     = (ulc_pkg::t_req'(i_in.req_type) == ulc_pkg::REQ_ADVANCE)
                     ? adv_cursor : r_cursor;
        hit        = found_w[CAPACITY];
        del_count  = r_count - CW'(1);
        del_cursor = found_w[r_cursor] ? (r_cursor - PW'(1)) : r_cursor;
        if (CW'(del_cursor) >= del_count) begin
            del_cursor = '0;
        end
    end

    // cell strobes
    always_comb begin
        ctl.ins = acc && (ulc_pkg::t_req'(i_in.req_type) == ulc_pkg::REQ_INSERT) && !full;
        ctl.del = acc && (ulc_pkg::t_req'(i_in.req_type) == ulc_pkg::REQ_DELETE) && hit;
    end

    // row of key cells
    assign found_w[0] = 1'b0;
    assign rd_w[0]    = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [KEY_BITS-1:0] next_entry;
        if (k + 1 < CAPACITY) begin : g_mid
            assign next_entry = entry_w[k+1];
        end else begin : g_last
            assign next_entry = '0;
        end
        ulc_cell #(
            .CAPACITY (CAPACITY),
            .KEY_BITS (KEY_BITS),
            .INDEX    (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_key        (key),
            .i_count      (r_count),
            .i_rd_idx     (rd_idx),
            .i_next_entry (next_entry),
            .i_found      (found_w[k]),
            .i_rd         (rd_w[k]),
            .o_entry      (entry_w[k]),
            .o_found      (found_w[k+1]),
            .o_rd         (rd_w[k+1])
        );
    end

    // next state and result
    always_comb begin
        n_count          = r_count;
        n_cursor         = r_cursor;
        n_out.status     = ulc_pkg::ST_OK;
        n_out.key_out    = '0;
        case (ulc_pkg::t_req'(i_in.req_type))
            ulc_pkg::REQ_INSERT: begin
                n_out.key_out = ulc_pkg::KEY_FIELD'(key);
                if (full) begin
                    n_out.status = ulc_pkg::ST_FULL;
                end else begin
                    n_cursor = PW'(r_count);
                    n_count  = r_count + CW'(1);
                end
            end
            ulc_pkg::REQ_DELETE: begin
                n_out.key_out = ulc_pkg::KEY_FIELD'(key);
                if (hit) begin
                    n_count  = del_count;
                    n_cursor = del_cursor;
                end else begin
                    n_out.status = ulc_pkg::ST_NOTFOUND;
                end
            end
            ulc_pkg::REQ_GET, ulc_pkg::REQ_ADVANCE: begin
                if (empty) begin
                    n_out.status = ulc_pkg::ST_EMPTY;
                end else begin
                    n_out.key_out = ulc_pkg::KEY_FIELD'(rd_w[CAPACITY]);
                    n_cursor      = rd_idx;
                end
            end
            ulc_pkg::REQ_CLEAR: begin
                n_count  = '0;
                n_cursor = '0;
            end
            default: begin
            end
        endcase
        n_out.entry_count = ulc_pkg::CNT_FIELD'(n_count);
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (acc) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // count stays within capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // cursor names a valid entry whenever the list is not empty
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CW'(r_cursor) < r_count))
        else $error("cursor outside the list");

    // a successful insert grows the list by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // a successful delete shrinks the list by one
    a_delete_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.del |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");

    // every accepted request leaves a result pending
    a_result_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted request left no result");

endmodule

`default_nettype wire
